@@ sv/kcs_pkg.sv @@
package kcs_pkg;

  localparam int MAX_KEYS = 64;
  localparam int ADDR_W   = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  localparam int VAL_W    = 32;
  localparam int IDX_W    = 6;
  localparam int ST_W     = 2;
  localparam int CNT_IN_W = 7;
  localparam int MODE_W   = 2;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam int FRAC_W   = 16;
  localparam int QUO_W    = FRAC_W + 1;
  localparam int MUL_A_W  = VAL_W + 2;
  localparam int MUL_B_W  = FRAC_W + 3;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 1'b1;

  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SMOOTH = 2'd1;

  localparam logic [ST_W-1:0] ST_INSIDE = 2'd0;
  localparam logic [ST_W-1:0] ST_FIRST  = 2'd1;
  localparam logic [ST_W-1:0] ST_LAST   = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] num;
    logic [VAL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ sv/kcs_ram.sv @@
module kcs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/kcs_div.sv @@
module kcs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kcs_pkg::div_req_t req_i,
  output kcs_pkg::div_rsp_t rsp_o
);

  localparam int STEP_W = $clog2(kcs_pkg::QUO_W + 1);

  logic                          run_q;
  logic                          done_q;
  logic                          first_q;
  logic                          zero_q;
  logic [STEP_W-1:0]             cnt_q;
  logic [kcs_pkg::VAL_W:0]       rem_q;
  logic [kcs_pkg::VAL_W-1:0]     den_q;
  logic [kcs_pkg::QUO_W-1:0]     quo_q;
  logic [kcs_pkg::VAL_W:0]       trial;
  logic                          ge;

  always_comb begin
    trial = first_q ? rem_q : {rem_q[kcs_pkg::VAL_W-1:0], 1'b0};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q   <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= STEP_W'(kcs_pkg::QUO_W);
      end else if (run_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= {1'b0, req_i.num};
      den_q  <= req_i.den;
      zero_q <= (req_i.den == '0);
      quo_q  <= '0;
    end else if (run_q) begin
      rem_q <= ge ? trial - {1'b0, den_q} : trial;
      quo_q <= {quo_q[kcs_pkg::QUO_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = zero_q ? '0 : quo_q;

endmodule

@@ sv/kcs_mul.sv @@
module kcs_mul (
  input  logic                                clk_i,
  input  logic signed [kcs_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [kcs_pkg::MUL_B_W-1:0] b_i,
  output logic signed [kcs_pkg::MUL_P_W-1:0] p_o
);

  logic signed [kcs_pkg::MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= kcs_pkg::MUL_P_W'(a_i) * kcs_pkg::MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ sv/keyframe_curve_sampler_top.sv @@
// Keyframe curve sampler: a write beat stores one key (time, value) in the key
// memory and returns no result. A sample beat scans the segments in key order,
// one memory read per cycle, and blends inside the first segment that encloses
// the sample time (linear, smoothstep or hold). The serial key scan, the
// 17-step fraction divider and the shared multiplier set how long a sample
// takes; a held result skips the divider and multiplier, and an empty curve
// skips the scan as well. Keys must be written before they are sampled; key
// memory has no reset.
module keyframe_curve_sampler_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic [kcs_pkg::IDX_W-1:0]          key_index_i,
  input  logic signed [kcs_pkg::VAL_W-1:0]   key_time_i,
  input  logic signed [kcs_pkg::VAL_W-1:0]   key_value_i,
  input  logic signed [kcs_pkg::VAL_W-1:0]   sample_time_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [kcs_pkg::VAL_W-1:0]   curve_value_o,
  output logic [kcs_pkg::IDX_W-1:0]          segment_o,
  output logic [kcs_pkg::ST_W-1:0]           status_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [kcs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [kcs_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int AW = kcs_pkg::ADDR_W;
  localparam int CW = kcs_pkg::CNT_W;
  localparam int VW = kcs_pkg::VAL_W;
  localparam int FW = kcs_pkg::FRAC_W;
  localparam int QW = kcs_pkg::QUO_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_TAIL, S_DIV, S_SQ, S_SF, S_SW, S_BL, S_BR, S_OUT
  } state_e;

  state_e                          state_q;
  logic [kcs_pkg::CNT_IN_W-1:0]    key_count_q;
  logic [kcs_pkg::MODE_W-1:0]      mode_q;
  logic [CW-1:0]                   n_q;
  logic [AW-1:0]                   idx_q;
  logic signed [VW-1:0]            ts_q;
  logic signed [VW-1:0]            first_t_q;
  logic signed [VW-1:0]            first_v_q;
  logic signed [VW-1:0]            prev_t_q;
  logic signed [VW-1:0]            prev_v_q;
  logic signed [VW-1:0]            y1_q;
  logic [QW-1:0]                   w_q;
  logic signed [VW-1:0]            res_val_q;
  logic [AW-1:0]                   res_seg_q;
  logic [kcs_pkg::ST_W-1:0]        res_st_q;
  logic                            out_valid_q;
  logic signed [VW-1:0]            out_val_q;
  logic [kcs_pkg::IDX_W-1:0]       out_seg_q;
  logic [kcs_pkg::ST_W-1:0]        out_st_q;

  logic                            in_acc;
  logic                            cfg_acc;
  logic [CW-1:0]                   n_d;
  logic                            ram_we;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [2*VW-1:0]                 ram_rdata;
  logic signed [VW-1:0]            rd_t;
  logic signed [VW-1:0]            rd_v;
  logic                            in_seg;
  logic                            at_last;
  logic                            out_load;
  logic signed [VW:0]              diff;
  logic [QW-1:0]                   prod_hi;
  kcs_pkg::div_req_t               div_req;
  kcs_pkg::div_rsp_t               div_rsp;
  logic signed [kcs_pkg::MUL_A_W-1:0] mul_a;
  logic signed [kcs_pkg::MUL_B_W-1:0] mul_b;
  logic signed [kcs_pkg::MUL_P_W-1:0] mul_p;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  assign n_d = (32'(key_count_q) > kcs_pkg::MAX_KEYS) ? CW'(kcs_pkg::MAX_KEYS)
                                                      : CW'(key_count_q);

  assign ram_we = in_acc && (kind_i == kcs_pkg::KIND_WRITE) &&
                  (32'(key_index_i) < kcs_pkg::MAX_KEYS);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        ram_re = in_acc && (kind_i == kcs_pkg::KIND_SAMPLE);
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q + AW'(1);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  kcs_ram #(
    .DEPTH (kcs_pkg::MAX_KEYS),
    .WIDTH (2 * VW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(key_index_i)),
    .wdata_i ({key_time_i, key_value_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_t    = ram_rdata[2*VW-1:VW];
  assign rd_v    = ram_rdata[VW-1:0];
  assign in_seg  = (ts_q >= prev_t_q) && (ts_q <= rd_t);
  assign at_last = (CW'(idx_q) + CW'(1)) == n_q;

  assign div_req.start = (state_q == S_SCAN) && (idx_q != '0) && in_seg &&
                         !mode_q[1];
  assign div_req.num   = ts_q - prev_t_q;
  assign div_req.den   = rd_t - prev_t_q;

  kcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign diff    = (VW+1)'(y1_q) - (VW+1)'(prev_v_q);
  assign prod_hi = mul_p[FW+QW-1:FW];

  always_comb begin
    mul_a = kcs_pkg::MUL_A_W'(signed'({1'b0, w_q}));
    mul_b = kcs_pkg::MUL_B_W'(signed'({1'b0, w_q}));
    case (state_q)
      S_SF: begin
        mul_a = kcs_pkg::MUL_A_W'(signed'({1'b0, prod_hi}));
        mul_b = kcs_pkg::MUL_B_W'(3 * (1 << FW)) -
                kcs_pkg::MUL_B_W'(signed'({1'b0, w_q, 1'b0}));
      end
      S_BL: begin
        mul_a = kcs_pkg::MUL_A_W'(diff);
      end
      default: begin
        mul_a = kcs_pkg::MUL_A_W'(signed'({1'b0, w_q}));
      end
    endcase
  end

  kcs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_count_q <= '0;
      mode_q      <= kcs_pkg::MODE_LINEAR;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index_i)
          kcs_pkg::CFG_KEY_COUNT:   key_count_q <= cfg_data_i[kcs_pkg::CNT_IN_W-1:0];
          kcs_pkg::CFG_INTERP_MODE: mode_q <= cfg_data_i[kcs_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && (kind_i == kcs_pkg::KIND_SAMPLE)) begin
            n_q   <= n_d;
            idx_q <= '0;
            state_q <= (n_d == '0) ? S_OUT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_q == '0) begin
            if (at_last) begin
              state_q <= S_TAIL;
            end else begin
              idx_q <= idx_q + AW'(1);
            end
          end else if (in_seg) begin
            state_q <= mode_q[1] ? S_OUT : S_DIV;
          end else if (at_last) begin
            state_q <= S_TAIL;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_TAIL: state_q <= S_OUT;
        S_DIV: begin
          if (div_rsp.done) begin
            state_q <= (mode_q == kcs_pkg::MODE_SMOOTH) ? S_SQ : S_BL;
          end
        end
        S_SQ:  state_q <= S_SF;
        S_SF:  state_q <= S_SW;
        S_SW:  state_q <= S_BL;
        S_BL:  state_q <= S_BR;
        S_BR:  state_q <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        ts_q      <= sample_time_i;
        res_val_q <= '0;
        res_seg_q <= '0;
        res_st_q  <= kcs_pkg::ST_EMPTY;
      end
      S_SCAN: begin
        if (idx_q == '0) begin
          first_t_q <= rd_t;
          first_v_q <= rd_v;
          prev_t_q  <= rd_t;
          prev_v_q  <= rd_v;
        end else if (in_seg) begin
          y1_q      <= rd_v;
          res_val_q <= prev_v_q;
          res_seg_q <= idx_q - AW'(1);
          res_st_q  <= kcs_pkg::ST_INSIDE;
        end else begin
          prev_t_q <= rd_t;
          prev_v_q <= rd_v;
        end
      end
      S_TAIL: begin
        if (ts_q <= first_t_q) begin
          res_val_q <= first_v_q;
          res_seg_q <= '0;
          res_st_q  <= kcs_pkg::ST_FIRST;
        end else if (ts_q >= prev_t_q) begin
          res_val_q <= prev_v_q;
          res_seg_q <= AW'(n_q - CW'(1));
          res_st_q  <= kcs_pkg::ST_LAST;
        end else begin
          res_val_q <= first_v_q;
          res_seg_q <= '0;
          res_st_q  <= kcs_pkg::ST_FIRST;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          w_q <= div_rsp.quo;
        end
      end
      S_SW: w_q <= prod_hi;
      S_BR: res_val_q <= prev_v_q + mul_p[FW+VW-1:FW];
      default: ;
    endcase
    if (out_load) begin
      out_val_q <= res_val_q;
      out_seg_q <= kcs_pkg::IDX_W'(res_seg_q);
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign curve_value_o = out_val_q;
  assign segment_o     = out_seg_q;
  assign status_o      = out_st_q;

endmodule

@@ sv/kcs_checker.sv @@
module kcs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             kind_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [kcs_pkg::VAL_W-1:0] curve_value_o,
  input logic [kcs_pkg::IDX_W-1:0]        segment_o,
  input logic [kcs_pkg::ST_W-1:0]         status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(curve_value_o) &&
    $stable(segment_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == kcs_pkg::ST_EMPTY) |->
    (curve_value_o == '0) && (segment_o == '0))
    else $error("empty curve result not zero");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == kcs_pkg::ST_FIRST) |-> (segment_o == '0))
    else $error("held first value with nonzero segment");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == kcs_pkg::KIND_WRITE) |=>
    !$rose(out_valid_o))
    else $error("result beat after a key write");

endmodule

bind keyframe_curve_sampler_top kcs_checker u_kcs_checker (.*);

@@ verif/keyframe_curve_sampler_top_tb.sv @@
`timescale 1ns / 100ps

module keyframe_curve_sampler_top_tb;
  import kcs_pkg::*;

  localparam int CLK_PERIOD    = 2;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 5000;
  localparam int ITEM_GOAL     = 1500;
  localparam int CNT_CFG_MAX   = (1 << CNT_IN_W) - 1;
  localparam longint Q_ONE     = 64'sd65536;

  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

  localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic signed [VAL_W-1:0] curve_value;
    logic [IDX_W-1:0]        segment;
    logic [ST_W-1:0]         status;
  } curve_res_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_e;

  typedef struct {
    row_e                    op;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_W-1:0]        reg_data;
    logic                    kind;
    logic [IDX_W-1:0]        slot;
    logic signed [VAL_W-1:0] ktime;
    logic signed [VAL_W-1:0] kvalue;
    logic signed [VAL_W-1:0] stime;
    bit                      typed;
    curve_res_t              res;
  } plan_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    kind_i;
  logic [IDX_W-1:0]        key_index_i;
  logic signed [VAL_W-1:0] key_time_i;
  logic signed [VAL_W-1:0] key_value_i;
  logic signed [VAL_W-1:0] sample_time_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [VAL_W-1:0] curve_value_o;
  logic [IDX_W-1:0]        segment_o;
  logic [ST_W-1:0]         status_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_W-1:0]        cfg_data_i;

  logic signed [VAL_W-1:0] shadow_key_time [MAX_KEYS];
  logic signed [VAL_W-1:0] shadow_key_value [MAX_KEYS];
  logic [CNT_IN_W-1:0]     shadow_count;
  logic [MODE_W-1:0]       shadow_mode;
  curve_res_t              pending_curve_q [$];

  logic signed [VAL_W-1:0] plan_time [MAX_KEYS];
  bit                      slot_loaded [MAX_KEYS];
  plan_row_t               directed_plan [$];

  bit                      chk_typed;
  curve_res_t              chk_result;
  curve_res_t              want;
  bit                      progress;
  int                      stall_cycles;
  int                      fail_count;
  int                      items_sent;
  int                      send_idle_pct;
  int                      recv_idle_pct;
  int                      phase_count;
  int                      phase_keys;
  logic [MODE_W-1:0]       phase_mode;

  keyframe_curve_sampler_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .key_index_i   (key_index_i),
    .key_time_i    (key_time_i),
    .key_value_i   (key_value_i),
    .sample_time_i (sample_time_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .curve_value_o (curve_value_o),
    .segment_o     (segment_o),
    .status_o      (status_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic curve_res_t predict_curve(input logic signed [VAL_W-1:0] stime);
    curve_res_t r;
    longint     ts, t0, t1, y0, y1, frac, q, w;
    int         n, i;
    n = (shadow_count > MAX_KEYS) ? MAX_KEYS : int'(shadow_count);
    ts = stime;
    if (n == 0) return curve_res_t'{32'sd0, '0, ST_EMPTY};
    for (i = 0; i + 1 < n; i++) begin
      t0 = shadow_key_time[i];
      t1 = shadow_key_time[i + 1];
      if (ts >= t0 && ts <= t1) begin
        y0 = shadow_key_value[i];
        y1 = shadow_key_value[i + 1];
        frac = (t1 == t0) ? 64'sd0 : ((ts - t0) <<< FRAC_W) / (t1 - t0);
        if (frac > Q_ONE) frac = Q_ONE;
        if (shadow_mode == MODE_LINEAR || shadow_mode == MODE_SMOOTH) begin
          w = frac;
          if (shadow_mode == MODE_SMOOTH) begin
            q = (frac * frac) >>> FRAC_W;
            w = (q * (3 * Q_ONE - 2 * frac)) >>> FRAC_W;
          end
          y0 = y0 + (((y1 - y0) * w) >>> FRAC_W);
        end
        r.curve_value = y0[VAL_W-1:0];
        r.segment = i[IDX_W-1:0];
        r.status = ST_INSIDE;
        return r;
      end
    end
    t0 = shadow_key_time[0];
    t1 = shadow_key_time[n - 1];
    if (ts > t0 && ts >= t1) begin
      r.curve_value = shadow_key_value[n - 1];
      r.segment = IDX_W'(n - 1);
      r.status = ST_LAST;
    end else begin
      r.curve_value = shadow_key_value[0];
      r.segment = '0;
      r.status = ST_FIRST;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        progress = 1'b1;
        if (cfg_index_i == CFG_KEY_COUNT) shadow_count = cfg_data_i[CNT_IN_W-1:0];
        else shadow_mode = cfg_data_i[MODE_W-1:0];
      end
      if (in_valid_i && in_ready_o) begin
        progress = 1'b1;
        if (kind_i == KIND_WRITE) begin
          shadow_key_time[key_index_i] = key_time_i;
          shadow_key_value[key_index_i] = key_value_i;
        end else if (chk_typed) begin
          pending_curve_q.push_back(chk_result);
        end else begin
          pending_curve_q.push_back(predict_curve(sample_time_i));
        end
      end
      if (out_valid_o && out_ready_i) begin
        progress = 1'b1;
        if (pending_curve_q.size() == 0) begin
          $error("unexpected result beat: curve_value %0d segment %0d status %0d",
                 curve_value_o, segment_o, status_o);
          fail_count++;
        end else begin
          want = pending_curve_q.pop_front();
          if (curve_value_o !== want.curve_value) begin
            $error("curve_value: expected %0d, got %0d", want.curve_value, curve_value_o);
            fail_count++;
          end
          if (segment_o !== want.segment) begin
            $error("segment: expected %0d, got %0d", want.segment, segment_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fail_count++;
          end
        end
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic longint unsigned rand_below(input longint unsigned bound);
    longint unsigned r;
    r = {$urandom, $urandom};
    return r % bound;
  endfunction

  function automatic logic signed [VAL_W-1:0] noise_time();
    if ($urandom_range(1) == 0) return $urandom;
    return $signed($urandom_range(20 * 65536)) - 10 * 65536;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_sample_time(input int n);
    longint lo, hi, v, span_lo, span_hi;
    int     k;
    if (n == 0) return $urandom;
    k = $urandom_range(n - 1);
    lo = plan_time[0];
    hi = plan_time[n - 1];
    span_lo = (lo < hi) ? lo : hi;
    span_hi = (lo < hi) ? hi : lo;
    case ($urandom_range(7))
      0: v = plan_time[k];
      1: v = longint'(plan_time[k]) + longint'($urandom_range(8)) - 4;
      2, 3: v = span_lo + longint'(rand_below(span_hi - span_lo + 1));
      4: v = lo - 1 - longint'(rand_below(262144));
      5: v = hi + 1 + longint'(rand_below(262144));
      6: v = longint'($signed($urandom));
      default: v = ($urandom_range(1) == 0) ? Q_MIN : Q_MAX;
    endcase
    if (v < Q_MIN) v = Q_MIN;
    if (v > Q_MAX) v = Q_MAX;
    return v[VAL_W-1:0];
  endfunction

  function automatic plan_row_t item_row(input logic kind, input logic [IDX_W-1:0] slot,
                                         input logic signed [VAL_W-1:0] ktime, kvalue, stime,
                                         input bit typed = 1'b0, input curve_res_t res = '0);
    plan_row_t row;
    row.op = ROW_ITEM;
    row.reg_idx = '0;
    row.reg_data = '0;
    row.kind = kind;
    row.slot = slot;
    row.ktime = ktime;
    row.kvalue = kvalue;
    row.stime = stime;
    row.typed = typed;
    row.res = res;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    plan_row_t row;
    row = item_row(KIND_WRITE, '0, '0, '0, '0);
    row.op = ROW_CFG;
    row.reg_idx = idx;
    row.reg_data = data;
    return row;
  endfunction

  task automatic send_item(input logic kind, input logic [IDX_W-1:0] slot,
                           input logic signed [VAL_W-1:0] ktime, kvalue, stime,
                           input bit typed, input curve_res_t res);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = kind;
    key_index_i = slot;
    key_time_i = ktime;
    key_value_i = kvalue;
    sample_time_i = stime;
    chk_typed = typed;
    chk_result = res;
    if (kind == KIND_WRITE) begin
      slot_loaded[slot] = 1'b1;
      plan_time[slot] = ktime;
    end
    items_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off input until every result is back and the block has gone quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_curve_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_ordered_keys(input int n);
    longint unsigned steps [MAX_KEYS];
    longint unsigned step_cap, total;
    longint          t;
    int              k;
    step_cap = ($urandom_range(3) == 0) ? 64'hFFFF_FFFF / ((n > 1) ? n - 1 : 1) : 64'd262144;
    total = 0;
    for (k = 1; k < n; k++) begin
      steps[k] = ($urandom_range(7) == 0) ? 64'd0 : rand_below(step_cap + 1);
      total += steps[k];
    end
    t = longint'(Q_MIN) + longint'(rand_below(64'h1_0000_0000 - total));
    for (k = 0; k < n; k++) begin
      if (k > 0) t += longint'(steps[k]);
      send_item(KIND_WRITE, k[IDX_W-1:0], t[VAL_W-1:0], $urandom, $urandom, 1'b0, '0);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KIND_WRITE;
    key_index_i = '0;
    key_time_i = '0;
    key_value_i = '0;
    sample_time_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_KEY_COUNT;
    cfg_data_i = '0;
    chk_typed = 1'b0;
    chk_result = '0;
    shadow_count = '0;
    shadow_mode = MODE_LINEAR;
    stall_cycles = 0;
    fail_count = 0;
    items_sent = 0;
    send_idle_pct = 12;
    recv_idle_pct = 88;
    foreach (slot_loaded[s]) slot_loaded[s] = 1'b0;

    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1,
                                     curve_res_t'{32'sd0, 6'd0, ST_EMPTY}));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd63, Q_MAX, Q_MAX, Q_MIN, 1'b1,
                                     curve_res_t'{32'sd0, 6'd0, ST_EMPTY}));
    directed_plan.push_back(item_row(KIND_WRITE, 6'd0, Q_MIN, Q_MIN, 32'sd0));
    directed_plan.push_back(item_row(KIND_WRITE, 6'd1, Q_MAX, Q_MAX, 32'sd0));
    directed_plan.push_back(item_row(KIND_WRITE, 6'd63, 32'sd0, 32'sh1234_5678, 32'sd0));
    directed_plan.push_back(cfg_row(CFG_KEY_COUNT, 7'd1));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, 32'sd5, 1'b1,
                                     curve_res_t'{Q_MIN, 6'd0, ST_LAST}));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, Q_MIN, 1'b1,
                                     curve_res_t'{Q_MIN, 6'd0, ST_FIRST}));
    directed_plan.push_back(cfg_row(CFG_KEY_COUNT, 7'd2));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, Q_MIN, 1'b1,
                                     curve_res_t'{Q_MIN, 6'd0, ST_INSIDE}));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, Q_MAX, 1'b1,
                                     curve_res_t'{Q_MAX, 6'd0, ST_INSIDE}));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, 32'sd0));
    directed_plan.push_back(cfg_row(CFG_INTERP_MODE, {5'd0, MODE_SMOOTH}));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, 32'sd0));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, 32'sh4000_0000));
    directed_plan.push_back(cfg_row(CFG_INTERP_MODE, {5'd0, MODE_HOLD}));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, 32'sh4000_0000, 1'b1,
                                     curve_res_t'{Q_MIN, 6'd0, ST_INSIDE}));
    directed_plan.push_back(cfg_row(CFG_INTERP_MODE, {5'h1F, MODE_SPARE}));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, 32'sh4000_0000, 1'b1,
                                     curve_res_t'{Q_MIN, 6'd0, ST_INSIDE}));
    directed_plan.push_back(cfg_row(CFG_INTERP_MODE, {5'd0, MODE_LINEAR}));
    directed_plan.push_back(item_row(KIND_WRITE, 6'd1, Q_MIN, 32'sd100, 32'sd0));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, Q_MIN, 1'b1,
                                     curve_res_t'{Q_MIN, 6'd0, ST_INSIDE}));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1,
                                     curve_res_t'{32'sd100, 6'd1, ST_LAST}));
    directed_plan.push_back(item_row(KIND_WRITE, 6'd0, 32'sh000A_0000, 32'sd1000, 32'sd0));
    directed_plan.push_back(item_row(KIND_WRITE, 6'd1, 32'sd0, 32'sd2000, 32'sd0));
    directed_plan.push_back(item_row(KIND_WRITE, 6'd2, 32'sh0005_0000, 32'sd3000, 32'sd0));
    directed_plan.push_back(cfg_row(CFG_KEY_COUNT, 7'd3));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, 32'sh0007_0000, 1'b1,
                                     curve_res_t'{32'sd1000, 6'd0, ST_FIRST}));
    directed_plan.push_back(item_row(KIND_SAMPLE, 6'd0, 32'sd0, 32'sd0, 32'sh0002_0000));

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].op == ROW_CFG) begin
        settle();
        write_reg(directed_plan[r].reg_idx, directed_plan[r].reg_data);
      end else begin
        send_item(directed_plan[r].kind, directed_plan[r].slot, directed_plan[r].ktime,
                  directed_plan[r].kvalue, directed_plan[r].stime, directed_plan[r].typed,
                  directed_plan[r].res);
      end
    end

    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= 2 * ITEM_GOAL / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= ITEM_GOAL / 3) begin
        send_idle_pct = 88;
        recv_idle_pct = 12;
      end
      case ($urandom_range(9))
        0: phase_count = 0;
        1: phase_count = 1;
        2: phase_count = 2;
        3: phase_count = MAX_KEYS;
        4: phase_count = CNT_CFG_MAX;
        5: phase_count = $urandom_range(CNT_CFG_MAX, MAX_KEYS + 1);
        default: phase_count = $urandom_range(12, 3);
      endcase
      phase_mode = $urandom_range(3);
      phase_keys = (phase_count > MAX_KEYS) ? MAX_KEYS : phase_count;
      settle();
      write_reg(CFG_KEY_COUNT, CFG_W'(phase_count));
      write_reg(CFG_INTERP_MODE, CFG_W'({$urandom_range(31), phase_mode}));
      if ($urandom_range(4) != 0) begin
        load_ordered_keys(phase_keys);
      end else begin
        repeat ($urandom_range(6)) begin
          send_item(KIND_WRITE, $urandom_range(63), noise_time(), $urandom, $urandom, 1'b0, '0);
        end
        for (int k = 0; k < phase_keys; k++) begin
          if (!slot_loaded[k]) begin
            send_item(KIND_WRITE, k[IDX_W-1:0], noise_time(), $urandom, $urandom, 1'b0, '0);
          end
        end
      end
      repeat ($urandom_range(30, 8)) begin
        if ($urandom_range(19) == 0) begin
          send_item(KIND_WRITE, $urandom_range(63), noise_time(), $urandom, $urandom, 1'b0, '0);
        end else begin
          send_item(KIND_SAMPLE, $urandom_range(63), $urandom, $urandom,
                    pick_sample_time(phase_keys), 1'b0, '0);
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ keyframe_curve_sampler_top.f @@
sv/kcs_pkg.sv
sv/kcs_ram.sv
sv/kcs_div.sv
sv/kcs_mul.sv
sv/keyframe_curve_sampler_top.sv
sv/kcs_checker.sv
verif/keyframe_curve_sampler_top_tb.sv
